// ===== hdl/best_fit_heap_allocator_macros.svh =====
// Assertion macros shared by the allocator modules.
`ifndef BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BFHA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BFHA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfha_pkg.sv =====
// Shared constants, codes and interface types of the heap allocator.
package bfha_pkg;

  localparam int unsigned HEAP_UNITS_DEF = 1024;
  localparam int unsigned MAX_FREE_DEF   = 512;
  localparam int unsigned UNITS_RESET    = 1024;
  localparam int unsigned UNIT_SHIFT     = 6;
  localparam int unsigned NEED_W         = 12;
  localparam int unsigned CFG_UNITS_W    = 11;
  localparam int unsigned SPLIT_MIN_REM  = 2;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // register indexes
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_UNITS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_ZERO    = 3'd2,
    ST_NULL    = 3'd3,
    ST_INVALID = 3'd4,
    ST_DOUBLE  = 3'd5,
    ST_FULL    = 3'd6
  } status_e;

  // live configuration, init pulses on every register write
  typedef struct packed {
    logic                   init;
    logic [31:0]            base;
    logic [CFG_UNITS_W-1:0] units;
  } cfg_t;

  // result of one request plus heap statistics
  typedef struct packed {
    logic                   valid;
    status_e                status;
    logic [31:0]            addr;
    logic [CFG_UNITS_W-1:0] free_units;
    logic [9:0]             entries;
  } res_t;

endpackage

// ===== hdl/bfha_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bfha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bfha_core.sv =====
// Allocator sequencer: header store, free table and the walk over them.
`include "best_fit_heap_allocator_macros.svh"
module bfha_core #(
  parameter int unsigned HEAP_UNITS = bfha_pkg::HEAP_UNITS_DEF,
  parameter int unsigned MAX_FREE   = bfha_pkg::MAX_FREE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           req_type_i,
  input  logic [16:0]    req_size_i,
  input  logic [31:0]    free_addr_i,
  input  bfha_pkg::cfg_t cfg_i,
  output logic           busy_o,
  output bfha_pkg::res_t res_o
);
  import bfha_pkg::*;

  localparam int unsigned UW = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
  localparam int unsigned LW = $clog2(HEAP_UNITS + 1);
  localparam int unsigned HW = LW + 1;
  localparam int unsigned FW = $clog2(MAX_FREE);
  localparam int unsigned EW = $clog2(MAX_FREE + 1);

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_ASCAN = 15'b000000000000100,
    S_ADEC  = 15'b000000000001000,
    S_AWR2  = 15'b000000000010000,
    S_SHDN  = 15'b000000000100000,
    S_SHUP  = 15'b000000001000000,
    S_FHDR  = 15'b000000010000000,
    S_FPOS  = 15'b000000100000000,
    S_FNXT  = 15'b000001000000000,
    S_FPRV  = 15'b000010000000000,
    S_FDEC  = 15'b000100000000000,
    S_FW1   = 15'b001000000000000,
    S_FW2   = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [UW-1:0] cnt_q, cnt_d;
  logic [EW-1:0] rd_q, rd_d, i1_q, i1_d, i2_q, i2_d;
  logic v1_q, v1_d, v2_q, v2_d;
  logic [UW-1:0] u2_q, u2_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic found_q, found_d;
  logic [EW-1:0] bi_q, bi_d;
  logic [UW-1:0] bu_q, bu_d;
  logic [LW-1:0] blen_q, blen_d;
  logic [UW-1:0] fu_q, fu_d, prev_q, prev_d;
  logic [LW-1:0] flen_q, flen_d, nlen_q, nlen_d, plen_q, plen_d, tot_q, tot_d;
  logic [EW-1:0] pos_q, pos_d;
  logic mn_q, mn_d, mp_q, mp_d;
  logic [EW-1:0] entries_q, entries_d;
  logic [LW-1:0] fut_q, fut_d;
  status_e status_q, status_d;
  logic [31:0] addr_q, addr_d;

  // memory ports
  logic hdr_we, ft_we;
  logic [UW-1:0] hdr_raddr, hdr_waddr;
  logic [HW-1:0] hdr_wdata, hdr_rdata;
  logic [FW-1:0] ft_raddr, ft_waddr;
  logic [UW-1:0] ft_wdata, ft_rdata;

  bfha_ram #(.WIDTH(HW), .DEPTH(HEAP_UNITS)) u_hdr_ram (
    .clk_i(clk_i), .we_i(hdr_we), .waddr_i(hdr_waddr), .wdata_i(hdr_wdata),
    .raddr_i(hdr_raddr), .rdata_o(hdr_rdata)
  );

  bfha_ram #(.WIDTH(UW), .DEPTH(MAX_FREE)) u_ft_ram (
    .clk_i(clk_i), .we_i(ft_we), .waddr_i(ft_waddr), .wdata_i(ft_wdata),
    .raddr_i(ft_raddr), .rdata_o(ft_rdata)
  );

  // derived values
  logic [LW-1:0] units_l, hlen, one_need;
  logic hflag, fits;
  logic [EW-1:0] rd_dec, i1_dec, i1_inc;
  logic [31:0] off, nxt, rem, data_addr;
  logic [NEED_W-1:0] need_in;

  assign units_l   = LW'(cfg_i.units);
  assign hlen      = hdr_rdata[LW-1:0];
  assign hflag     = hdr_rdata[LW];
  assign rd_dec    = rd_q - EW'(1);
  assign i1_dec    = i1_q - EW'(1);
  assign i1_inc    = i1_q + EW'(1);
  assign off       = free_addr_i - cfg_i.base - 32'd64;
  assign nxt       = 32'(fu_q) + 32'(flen_q);
  assign rem       = 32'(blen_q) - 32'd1 - 32'(need_q);
  assign data_addr = cfg_i.base + ((32'(bu_q) + 32'd1) << UNIT_SHIFT);
  assign need_in   = NEED_W'((18'(req_size_i) + 18'd63) >> UNIT_SHIFT);
  assign one_need  = LW'(32'(need_q) + 32'd1);
  assign fits      = (hlen != '0) && ((32'(hlen) - 32'd1) >= 32'(need_q));

  // sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rd_d = rd_q; i1_d = i1_q; i2_d = i2_q;
    v1_d = 1'b0; v2_d = 1'b0; u2_d = u2_q; need_d = need_q; found_d = found_q;
    bi_d = bi_q; bu_d = bu_q; blen_d = blen_q; fu_d = fu_q; prev_d = prev_q;
    flen_d = flen_q; nlen_d = nlen_q; plen_d = plen_q; tot_d = tot_q;
    pos_d = pos_q; mn_d = mn_q; mp_d = mp_q; entries_d = entries_q; fut_d = fut_q;
    status_d = status_q; addr_d = addr_q;
    hdr_we = 1'b0; hdr_waddr = '0; hdr_wdata = '0; hdr_raddr = '0;
    ft_we = 1'b0; ft_waddr = '0; ft_wdata = '0; ft_raddr = '0;

    unique case (state_q)
      // sweep the header store, unit 0 becomes the whole heap
      S_CLEAR: begin
        hdr_we    = 1'b1;
        hdr_waddr = cnt_q;
        hdr_wdata = (cnt_q == '0) ? {1'b1, units_l} : '0;
        if (cnt_q == '0) begin
          ft_we     = 1'b1;
          entries_d = EW'(1);
          fut_d     = units_l;
        end
        if (cnt_q == UW'(HEAP_UNITS - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + UW'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          addr_d = '0;
          rd_d   = '0;
          if (req_type_i == REQ_ALLOC) begin
            if (req_size_i == '0) begin
              status_d = ST_ZERO;
              state_d  = S_DONE;
            end else begin
              need_d  = need_in;
              found_d = 1'b0;
              state_d = S_ASCAN;
            end
          end else begin
            priority if (free_addr_i == '0) begin
              status_d = ST_NULL;
              state_d  = S_DONE;
            end else if (off[5:0] != '0 || 32'(off[31:6]) >= 32'(units_l)) begin
              status_d = ST_INVALID;
              state_d  = S_DONE;
            end else begin
              fu_d      = UW'(off[31:6]);
              hdr_raddr = UW'(off[31:6]);
              state_d   = S_FHDR;
            end
          end
        end
      end
      // best-fit walk: table read, then header read, one entry per cycle
      S_ASCAN: begin
        if (rd_q < entries_q) begin
          ft_raddr = rd_q[FW-1:0];
          v1_d     = 1'b1;
          i1_d     = rd_q;
          rd_d     = rd_q + EW'(1);
        end
        if (v1_q) begin
          hdr_raddr = ft_rdata;
          v2_d      = 32'(ft_rdata) < 32'(units_l);
          i2_d      = i1_q;
          u2_d      = ft_rdata;
        end
        if (v2_q && fits && (!found_q || hlen < blen_q)) begin
          found_d = 1'b1;
          bi_d    = i2_q;
          bu_d    = u2_q;
          blen_d  = hlen;
        end
        if (rd_q >= entries_q && !v1_q && !v2_q) begin
          state_d = S_ADEC;
        end
      end
      S_ADEC: begin
        if (!found_q) begin
          status_d = ST_OOM;
          state_d  = S_DONE;
        end else begin
          status_d = ST_OK;
          addr_d   = data_addr;
          if (rem > 32'(SPLIT_MIN_REM)) begin
            // split: remainder stays in the table at the same slot
            hdr_we    = 1'b1;
            hdr_waddr = UW'(32'(bu_q) + 32'd1 + 32'(need_q));
            hdr_wdata = {1'b1, LW'(rem)};
            ft_we     = 1'b1;
            ft_waddr  = bi_q[FW-1:0];
            ft_wdata  = UW'(32'(bu_q) + 32'd1 + 32'(need_q));
            fut_d     = fut_q - one_need;
            state_d   = S_AWR2;
          end else begin
            hdr_we    = 1'b1;
            hdr_waddr = bu_q;
            hdr_wdata = {1'b0, blen_q};
            fut_d     = fut_q - blen_q;
            rd_d      = bi_q + EW'(1);
            state_d   = S_SHDN;
          end
        end
      end
      S_AWR2: begin
        hdr_we    = 1'b1;
        hdr_waddr = bu_q;
        hdr_wdata = {1'b0, one_need};
        state_d   = S_DONE;
      end
      // close the gap: entry k moves to k-1
      S_SHDN: begin
        if (rd_q < entries_q) begin
          ft_raddr = rd_q[FW-1:0];
          v1_d     = 1'b1;
          i1_d     = rd_q;
          rd_d     = rd_q + EW'(1);
        end
        if (v1_q) begin
          ft_we    = 1'b1;
          ft_waddr = i1_dec[FW-1:0];
          ft_wdata = ft_rdata;
        end
        if (rd_q >= entries_q && !v1_q) begin
          entries_d = entries_q - EW'(1);
          state_d   = S_DONE;
        end
      end
      // open a gap at pos: entry k moves to k+1, top down
      S_SHUP: begin
        if (rd_q > pos_q) begin
          ft_raddr = rd_dec[FW-1:0];
          v1_d     = 1'b1;
          i1_d     = rd_dec;
          rd_d     = rd_dec;
        end
        if (v1_q) begin
          ft_we    = 1'b1;
          ft_waddr = i1_inc[FW-1:0];
          ft_wdata = ft_rdata;
        end
        if (rd_q <= pos_q && !v1_q) begin
          ft_we     = 1'b1;
          ft_waddr  = pos_q[FW-1:0];
          ft_wdata  = fu_q;
          entries_d = entries_q + EW'(1);
          state_d   = S_DONE;
        end
      end
      S_FHDR: begin
        priority if (hdr_rdata == '0) begin
          status_d = ST_INVALID;
          state_d  = S_DONE;
        end else if (hflag) begin
          status_d = ST_DOUBLE;
          state_d  = S_DONE;
        end else begin
          flen_d  = hlen;
          pos_d   = '0;
          prev_d  = '0;
          state_d = S_FPOS;
        end
      end
      // count entries below the freed unit and keep the last of them
      S_FPOS: begin
        if (rd_q < entries_q) begin
          ft_raddr = rd_q[FW-1:0];
          v1_d     = 1'b1;
          rd_d     = rd_q + EW'(1);
        end
        if (v1_q && ft_rdata < fu_q) begin
          pos_d  = pos_q + EW'(1);
          prev_d = ft_rdata;
        end
        if (rd_q >= entries_q && !v1_q) begin
          state_d = S_FNXT;
        end
      end
      S_FNXT: begin
        hdr_raddr = UW'(nxt);
        state_d   = S_FPRV;
      end
      S_FPRV: begin
        mn_d      = (nxt < 32'(units_l)) && hflag && (pos_q < entries_q);
        nlen_d    = hlen;
        hdr_raddr = prev_q;
        state_d   = S_FDEC;
      end
      S_FDEC: begin
        mp_d   = (pos_q != '0) && ((32'(prev_q) + 32'(hlen)) == 32'(fu_q));
        plen_d = hlen;
        if (!mn_q && !mp_d && 32'(entries_q) >= 32'(MAX_FREE)) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          status_d = ST_OK;
          fut_d    = fut_q + flen_q;
          tot_d    = flen_q + (mn_q ? nlen_q : '0);
          if (mn_q) begin
            hdr_we    = 1'b1;
            hdr_waddr = UW'(nxt);
          end
          state_d = S_FW1;
        end
      end
      S_FW1: begin
        hdr_we    = 1'b1;
        hdr_waddr = fu_q;
        if (mp_q) begin
          state_d = S_FW2;
        end else begin
          hdr_wdata = {1'b1, tot_q};
          if (mn_q) begin
            ft_we    = 1'b1;
            ft_waddr = pos_q[FW-1:0];
            ft_wdata = fu_q;
            state_d  = S_DONE;
          end else begin
            rd_d    = entries_q;
            state_d = S_SHUP;
          end
        end
      end
      // previous block absorbs everything
      S_FW2: begin
        hdr_we    = 1'b1;
        hdr_waddr = prev_q;
        hdr_wdata = {1'b1, plen_q + tot_q};
        if (mn_q) begin
          rd_d    = pos_q + EW'(1);
          state_d = S_SHDN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
        cnt_d   = '0;
      end
    endcase

    // any register write restarts the clearing pass
    if (cfg_i.init) begin
      state_d = S_CLEAR;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      entries_q <= '0;
      fut_q     <= '0;
      rd_q      <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      entries_q <= entries_d;
      fut_q     <= fut_d;
      rd_q      <= rd_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    i1_q <= i1_d; i2_q <= i2_d; u2_q <= u2_d; need_q <= need_d;
    found_q <= found_d; bi_q <= bi_d; bu_q <= bu_d; blen_q <= blen_d;
    fu_q <= fu_d; prev_q <= prev_d; flen_q <= flen_d; nlen_q <= nlen_d;
    plen_q <= plen_d; tot_q <= tot_d; pos_q <= pos_d; mn_q <= mn_d; mp_q <= mp_d;
    status_q <= status_d; addr_q <= addr_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign res_o.valid      = (state_q == S_DONE);
  assign res_o.status     = status_q;
  assign res_o.addr       = addr_q;
  assign res_o.free_units = CFG_UNITS_W'(fut_q);
  assign res_o.entries    = 10'(entries_q);

  `BFHA_ASSERT_NXT(a_strobe_single, res_o.valid, !res_o.valid, "result strobe held")
  `BFHA_ASSERT_IMP(a_entries_bound, 1'b1, 32'(entries_q) <= 32'(MAX_FREE), "table overrun")
  `BFHA_ASSERT_IMP(a_fut_bound, state_q == S_IDLE, fut_q <= units_l, "free units exceed heap")
  `BFHA_ASSERT_NXT(a_accept_busy, start_i && state_q == S_IDLE, busy_o, "accepted but idle")

endmodule

// ===== hdl/best_fit_heap_allocator.sv =====
// Best-fit heap allocator top level: configuration registers and result ports.
//
// Usage: raise start with req_type/req_size/free_addr while busy is low; the
// request transfers at that clock edge. One result follows, shown for exactly
// one cycle with done_o high: status, alloc_addr and the used/free byte and
// free block counts after the request. The receiver cannot stall results.
// Zero size allocates and null or bad-range frees finish without a walk; a
// free of an unknown or already free block ends after its header read. An
// allocate walks the free table and may then close a table slot when a
// block leaves it; a free walks it and may then open or close a table slot.
// The walk reads one free table entry per cycle through the table RAM, then
// one header RAM read each.
// Reset, and every register write, starts a clearing pass over the header
// RAM during which busy is high; the heap then is one free block.
// Registers may be written any time the block is idle.
module best_fit_heap_allocator #(
  parameter int unsigned HEAP_UNITS = bfha_pkg::HEAP_UNITS_DEF,
  parameter int unsigned MAX_FREE   = bfha_pkg::MAX_FREE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [16:0] req_size_i,
  input  logic [31:0] free_addr_i,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] alloc_addr_o,
  output logic [16:0] used_bytes_o,
  output logic [16:0] free_bytes_o,
  output logic [9:0]  free_block_count_o
);
  import bfha_pkg::*;

  localparam int unsigned RESET_UNITS =
    (HEAP_UNITS < UNITS_RESET) ? HEAP_UNITS : UNITS_RESET;

  logic [31:0]            base_q, base_d;
  logic [CFG_UNITS_W-1:0] units_q, units_d, units_clamp;
  cfg_t                   cfg;
  res_t                   res;
  logic                   core_busy;

  // clamp the unit count to the supported range
  always_comb begin
    priority if (32'(cfg_wdata_i[CFG_UNITS_W-1:0]) < 32'd4) begin
      units_clamp = CFG_UNITS_W'(4);
    end else if (32'(cfg_wdata_i[CFG_UNITS_W-1:0]) > 32'(HEAP_UNITS)) begin
      units_clamp = CFG_UNITS_W'(HEAP_UNITS);
    end else begin
      units_clamp = cfg_wdata_i[CFG_UNITS_W-1:0];
    end
  end

  // register writes
  always_comb begin
    base_d  = base_q;
    units_d = units_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_HEAP_BASE:  base_d  = {cfg_wdata_i[31:6], 6'b0};
        REG_HEAP_UNITS: units_d = units_clamp;
        default:        base_d  = base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      units_q <= CFG_UNITS_W'(RESET_UNITS);
    end else begin
      base_q  <= base_d;
      units_q <= units_d;
    end
  end

  assign cfg.init  = cfg_we_i;
  assign cfg.base  = base_q;
  assign cfg.units = units_q;

  bfha_core #(.HEAP_UNITS(HEAP_UNITS), .MAX_FREE(MAX_FREE)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .req_size_i  (req_size_i),
    .free_addr_i (free_addr_i),
    .cfg_i       (cfg),
    .busy_o      (core_busy),
    .res_o       (res)
  );

  // result ports, byte counts are the 64-byte unit counts times 64
  assign busy               = core_busy;
  assign done_o             = res.valid;
  assign status_o           = res.status;
  assign alloc_addr_o       = res.addr;
  assign used_bytes_o       = 17'({CFG_UNITS_W'(units_q - res.free_units), 6'b0});
  assign free_bytes_o       = 17'({res.free_units, 6'b0});
  assign free_block_count_o = res.entries;

endmodule

// ===== dv/best_fit_heap_allocator_tb.sv =====
// Testbench for the best-fit heap allocator: random and directed requests, checked per result.
`timescale 1ns / 100ps

module best_fit_heap_allocator_tb;
  import bfha_pkg::*;

  localparam int unsigned UNITS_MAX  = 1024;
  localparam int unsigned TABLE_MAX  = 512;
  localparam int unsigned LIMIT      = 6000000;
  localparam int unsigned DRAIN_WAIT = 2 * TABLE_MAX + 20;

  typedef struct {
    status_e     st;
    logic [31:0] addr;
    logic [16:0] used;
    logic [16:0] avail;
    logic [9:0]  blocks;
  } heap_result_t;

  // Allocator state mirror plus the queue of results still to arrive
  class heap_scoreboard;
    logic [31:0]   base;
    int unsigned   units;
    int unsigned   blk_len[UNITS_MAX];
    bit            blk_free[UNITS_MAX];
    int unsigned   free_list[$];
    int unsigned   free_units;
    heap_result_t  awaited[$];
    int unsigned   errors;

    function new();
      base   = '0;
      units  = UNITS_MAX;
      errors = 0;
      init_heap();
    endfunction

    function void init_heap();
      foreach (blk_len[i]) begin
        blk_len[i]  = 0;
        blk_free[i] = 0;
      end
      blk_len[0]  = units;
      blk_free[0] = 1;
      free_list   = {0};
      free_units  = units;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == REG_HEAP_BASE) begin
        base = val & 32'hFFFF_FFC0;
      end else begin
        units = val[10:0];
        if (units < 4) units = 4;
        if (units > UNITS_MAX) units = UNITS_MAX;
      end
      init_heap();
    endfunction

    // best fit, lowest address on a tie
    function status_e allocate(logic [16:0] size, output logic [31:0] addr);
      int unsigned need, bi, bu, blen, rem, len, u, nu;
      bit found;
      addr = '0;
      found = 0;
      bi = 0; bu = 0; blen = 0;
      if (size == 0) return ST_ZERO;
      need = (size + 63) / 64;
      foreach (free_list[i]) begin
        u = free_list[i];
        len = blk_len[u];
        if (u >= units || len == 0 || len - 1 < need) continue;
        if (!found || len < blen) begin
          found = 1; bi = i; bu = u; blen = len;
        end
      end
      if (!found) return ST_OOM;
      rem = blen - 1 - need;
      if (rem > 2) begin
        nu = bu + 1 + need;
        blk_len[nu]  = rem;
        blk_free[nu] = 1;
        free_list[bi] = nu;
        blk_len[bu]  = 1 + need;
        free_units  -= 1 + need;
      end else begin
        free_list.delete(bi);
        free_units -= blen;
      end
      blk_free[bu] = 0;
      addr = base + (bu + 1) * 64;
      return ST_OK;
    endfunction

    // release with merge of free neighbors on both sides
    function status_e release_block(logic [31:0] addr);
      logic [31:0] off;
      int unsigned u, len, pos, nxt, p;
      bit mnext, mprev;
      if (addr == 0) return ST_NULL;
      off = addr - base - 32'd64;
      if (off[5:0] != 0) return ST_INVALID;
      if (off[31:6] >= units) return ST_INVALID;
      u = off[31:6];
      if (blk_len[u] == 0) return ST_INVALID;
      if (blk_free[u]) return ST_DOUBLE;
      len = blk_len[u];
      pos = 0;
      while (pos < free_list.size() && free_list[pos] < u) pos++;
      nxt = u + len;
      mnext = (nxt < units) && blk_free[nxt] && (pos < free_list.size());
      mprev = 0;
      p = 0;
      if (pos > 0) begin
        p = free_list[pos - 1];
        mprev = (p + blk_len[p] == u);
      end
      if (!mnext && !mprev && free_list.size() >= TABLE_MAX) return ST_FULL;
      free_units += len;
      if (mnext) begin
        len += blk_len[nxt];
        blk_len[nxt]  = 0;
        blk_free[nxt] = 0;
      end
      if (mprev) begin
        blk_len[p] += len;
        blk_len[u]  = 0;
        blk_free[u] = 0;
        if (mnext) free_list.delete(pos);
      end else if (mnext) begin
        blk_len[u]  = len;
        blk_free[u] = 1;
        free_list[pos] = u;
      end else begin
        blk_len[u]  = len;
        blk_free[u] = 1;
        free_list.insert(pos, u);
      end
      return ST_OK;
    endfunction

    // accepted request: update the mirror, queue the result, return its address
    function logic [31:0] note_request(logic kind, logic [16:0] size, logic [31:0] faddr);
      heap_result_t r;
      r.addr = '0;
      if (kind == REQ_ALLOC) r.st = allocate(size, r.addr);
      else r.st = release_block(faddr);
      r.used   = 17'((units - free_units) * 64);
      r.avail  = 17'(free_units * 64);
      r.blocks = 10'(free_list.size());
      awaited.push_back(r);
      return r.addr;
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] addr, logic [16:0] used,
                               logic [16:0] avail, logic [9:0] blocks);
      heap_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing awaited: status %0d", st);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.st || addr !== e.addr || used !== e.used || avail !== e.avail ||
          blocks !== e.blocks) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status %0d/%0d addr %h/%h used %0d/%0d free %0d/%0d cnt %0d/%0d",
                   e.st, st, e.addr, addr, e.used, used, e.avail, avail, e.blocks, blocks);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        req_type_i;
  logic [16:0] req_size_i;
  logic [31:0] free_addr_i;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [31:0] cfg_wdata_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] alloc_addr_o;
  logic [16:0] used_bytes_o;
  logic [16:0] free_bytes_o;
  logic [9:0]  free_block_count_o;

  heap_scoreboard sb = new();
  logic [31:0]    live_addrs[$];
  logic [31:0]    freed_addrs[$];
  int unsigned    idle_pct;
  int unsigned    burst_left;
  int unsigned    cycles;

  best_fit_heap_allocator u_top (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .req_size_i, .free_addr_i,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i, .done_o, .status_o, .alloc_addr_o,
    .used_bytes_o, .free_bytes_o, .free_block_count_o
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(status_o, alloc_addr_o, used_bytes_o, free_bytes_o, free_block_count_o);
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one transfer; start stays high afterwards unless the caller lowers it
  task automatic send_req(logic kind, logic [16:0] size, logic [31:0] faddr,
                          output logic [31:0] got);
    int unsigned gap;
    gap = 0;
    if (burst_left > 0) burst_left--;
    else begin
      if ($urandom_range(19) == 0) burst_left = $urandom_range(30, 5);
      while ($urandom_range(99) < idle_pct && gap < 80) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    req_type_i  <= kind;
    req_size_i  <= size;
    free_addr_i <= faddr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    got = sb.note_request(kind, size, faddr);
    if (kind == REQ_ALLOC && got != 0) live_addrs.push_back(got);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    live_addrs.delete();
    freed_addrs.delete();
  endtask

  task automatic free_live(int unsigned idx);
    logic [31:0] a, dummy;
    a = live_addrs[idx];
    live_addrs.delete(idx);
    send_req(REQ_FREE, '0, a, dummy);
    freed_addrs.push_back(a);
    if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
  endtask

  // random mix: mostly valid traffic, some broken frees and odd sizes
  task automatic random_items(int unsigned n);
    int unsigned k, pick, span;
    logic [31:0] a, dummy;
    logic [16:0] sz;
    span = sb.units * 64;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (live_addrs.size() > 40) pick = 60;
      if (pick < 50 || live_addrs.size() == 0 && pick < 88) begin
        case ($urandom_range(19))
          0:       sz = '0;
          1:       sz = 17'($urandom);
          2, 3:    sz = 17'($urandom_range(span, 1));
          4, 5:    sz = 17'($urandom_range(span / 4, 1));
          default: sz = 17'($urandom_range(192, 1));
        endcase
        send_req(REQ_ALLOC, sz, '0, dummy);
      end else if (pick < 88) begin
        free_live($urandom_range(live_addrs.size() - 1));
      end else if (pick < 92 && freed_addrs.size() != 0) begin
        send_req(REQ_FREE, '0, freed_addrs[$urandom_range(freed_addrs.size() - 1)], dummy);
      end else begin
        case ($urandom_range(4))
          0:       a = '0;
          1:       a = $urandom;
          2:       a = sb.base + 64 * $urandom_range(sb.units) + $urandom_range(63, 1);
          3:       a = sb.base + 64 * ($urandom_range(sb.units + 8, sb.units));
          default: a = sb.base + 64 * $urandom_range(sb.units);
        endcase
        send_req(REQ_FREE, '0, a, dummy);
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] a1, a2, a3, a4, dummy;
    cycles      = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type_i  = REQ_ALLOC;
    req_size_i  = '0;
    free_addr_i = '0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_HEAP_BASE;
    cfg_wdata_i = '0;
    idle_pct    = 27;
    burst_left  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size edges, null, bad, unknown and double frees, merges on both sides
    send_req(REQ_ALLOC, 17'd0, '0, dummy);
    send_req(REQ_ALLOC, 17'd65536, '0, dummy);
    send_req(REQ_ALLOC, 17'h1FFFF, '0, dummy);
    send_req(REQ_ALLOC, 17'd1, '0, a1);
    send_req(REQ_ALLOC, 17'd65, '0, a2);
    send_req(REQ_ALLOC, 17'd64, '0, a3);
    send_req(REQ_ALLOC, 17'd100, '0, a4);
    send_req(REQ_FREE, '0, 32'd0, dummy);
    send_req(REQ_FREE, '0, a2 + 32'd1, dummy);
    send_req(REQ_FREE, '0, 32'hFFFF_FFFF, dummy);
    send_req(REQ_FREE, '0, a2 + 32'd64, dummy);
    send_req(REQ_FREE, '0, 32'd65536 + 32'd64, dummy);
    send_req(REQ_FREE, '0, a1, dummy);
    send_req(REQ_FREE, '0, a3, dummy);
    send_req(REQ_FREE, '0, a1, dummy);
    send_req(REQ_FREE, '0, a2, dummy);
    send_req(REQ_ALLOC, 17'd128, '0, dummy);
    send_req(REQ_ALLOC, 17'd64, '0, dummy);
    send_req(REQ_FREE, '0, a4, dummy);
    live_addrs.delete();
    drain();

    // tiny heap at the top of the address space: data of unit 0 sits at 0
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_UNITS, 32'd2);
    send_req(REQ_ALLOC, 17'd1, '0, a1);
    send_req(REQ_FREE, '0, a1, dummy);
    send_req(REQ_ALLOC, 17'd128, '0, dummy);
    send_req(REQ_ALLOC, 17'd129, '0, dummy);
    send_req(REQ_FREE, '0, 32'hFFFF_FFC0, dummy);
    random_items(30);

    // sender idles often-ish, full heap via clamp
    write_reg(REG_HEAP_BASE, {$urandom} & 32'hFFFF_FFC0);
    write_reg(REG_HEAP_UNITS, 32'h7FF);
    idle_pct = 27;
    random_items(340);

    // sender idles heavily, mid-size heap
    write_reg(REG_HEAP_BASE, 32'h0001_0000);
    write_reg(REG_HEAP_UNITS, $urandom_range(200, 16));
    idle_pct = 81;
    random_items(330);

    // back to back
    write_reg(REG_HEAP_BASE, $urandom);
    write_reg(REG_HEAP_UNITS, 32'd1024);
    idle_pct = 0;
    random_items(330);

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
